@@ rtl/crtc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// crtc_pkg
// shared types and constants for the cartridge real-time clock register block
// ----------------------------------------------------------------------------
package crtc_pkg;

  localparam int FUNC_W      = 2;
  localparam int ADDR_W      = 8;
  localparam int BYTE_W      = 8;
  localparam int PRESCALE_W  = 23;
  localparam int SEC_W       = 6;
  localparam int MIN_W       = 6;
  localparam int HOUR_W      = 5;
  localparam int DAY_W       = 9;
  localparam int LATCH_W     = SEC_W + MIN_W + HOUR_W + BYTE_W + BYTE_W;
  localparam int IN_DATA_W   = ADDR_W + BYTE_W;

  localparam logic [PRESCALE_W-1:0] TICKS_PER_SECOND = 23'd4194304;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_WRITE = 2'd2,
    FUNC_LATCH = 2'd3
  } func_t;

  localparam logic [ADDR_W-1:0] REG_SEC      = 8'h08;
  localparam logic [ADDR_W-1:0] REG_MIN      = 8'h09;
  localparam logic [ADDR_W-1:0] REG_HOUR     = 8'h0A;
  localparam logic [ADDR_W-1:0] REG_DAY_LOW  = 8'h0B;
  localparam logic [ADDR_W-1:0] REG_DAY_HIGH = 8'h0C;

  localparam logic [BYTE_W-1:0] MASK_SEC      = 8'h3F;
  localparam logic [BYTE_W-1:0] MASK_MIN      = 8'h3F;
  localparam logic [BYTE_W-1:0] MASK_HOUR     = 8'h1F;
  localparam logic [BYTE_W-1:0] MASK_DAY_HIGH = 8'hC1;
  localparam logic [BYTE_W-1:0] READ_UNKNOWN  = 8'hFF;

  localparam int DH_DAY_BIT   = 0;
  localparam int DH_HALT_BIT  = 6;
  localparam int DH_CARRY_BIT = 7;

  localparam logic [SEC_W:0]  SEC_WRAP  = 7'd60;
  localparam logic [MIN_W:0]  MIN_WRAP  = 7'd60;
  localparam logic [HOUR_W:0] HOUR_WRAP = 6'd24;

endpackage : crtc_pkg
`default_nettype wire

@@ rtl/cartridge_rtc_registers_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cartridge_rtc_registers_core
// time-of-day clock with a prescaler, latch copy and byte register window
// ----------------------------------------------------------------------------
// Every request (tick, register read, register write or latch) is taken and
// all of its effect on the clock state is applied at the accepting edge; a
// new request can be taken on every cycle while tready is high. Each request
// gives exactly one result byte, registered and valid on the master side in
// the cycle after acceptance when the master side is not stalled. A two-entry output buffer
// (result register plus skid register) lets the slave side keep accepting
// while one result waits; tready drops only when both entries are full.
module cartridge_rtc_registers_core (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // reg_addr[7:0], write_data[15:8]
  input  wire logic [crtc_pkg::IN_DATA_W-1:0] s_axis_tdata,
  // func[1:0]
  input  wire logic [crtc_pkg::FUNC_W-1:0]    s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // read_data[7:0]
  output logic [crtc_pkg::BYTE_W-1:0]         m_axis_tdata
);
  import crtc_pkg::*;

  logic [PRESCALE_W-1:0] prescale_count;
  logic [SEC_W-1:0]      sec_count;
  logic [MIN_W-1:0]      min_count;
  logic [HOUR_W-1:0]     hour_count;
  logic [BYTE_W-1:0]     day_low_byte;
  logic [BYTE_W-1:0]     day_high_flags;
  logic [LATCH_W-1:0]    latched_time;

  logic [PRESCALE_W-1:0] prescale_next;
  logic [SEC_W-1:0]      sec_next;
  logic [MIN_W-1:0]      min_next;
  logic [HOUR_W-1:0]     hour_next;
  logic [BYTE_W-1:0]     day_low_next;
  logic [BYTE_W-1:0]     day_high_next;
  logic [LATCH_W-1:0]    latched_next;
  logic [BYTE_W-1:0]     result;

  logic                  out_valid;
  logic [BYTE_W-1:0]     out_data;
  logic                  skid_valid;
  logic [BYTE_W-1:0]     skid_data;

  func_t                 func;
  logic [ADDR_W-1:0]     reg_addr;
  logic [BYTE_W-1:0]     write_data;
  logic                  accept_in;
  logic                  take_out;

  logic [PRESCALE_W-1:0] prescale_inc;
  logic [SEC_W:0]        sec_inc;
  logic [MIN_W:0]        min_inc;
  logic [HOUR_W:0]       hour_inc;
  logic [DAY_W:0]        day_inc;

  assign func       = func_t'(s_axis_tuser);
  assign reg_addr   = s_axis_tdata[ADDR_W-1:0];
  assign write_data = s_axis_tdata[IN_DATA_W-1:ADDR_W];

  assign s_axis_tready = !skid_valid;
  assign accept_in     = s_axis_tvalid && s_axis_tready;
  assign take_out      = out_valid && m_axis_tready;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  assign prescale_inc = prescale_count + 1'b1;
  assign sec_inc      = {1'b0, sec_count} + 1'b1;
  assign min_inc      = {1'b0, min_count} + 1'b1;
  assign hour_inc     = {1'b0, hour_count} + 1'b1;
  assign day_inc      = {1'b0, day_high_flags[DH_DAY_BIT], day_low_byte} + 1'b1;

  always_comb begin
    prescale_next = prescale_count;
    sec_next      = sec_count;
    min_next      = min_count;
    hour_next     = hour_count;
    day_low_next  = day_low_byte;
    day_high_next = day_high_flags;
    latched_next  = latched_time;
    result        = '0;
    case (func)
      FUNC_TICK: begin
        if (!day_high_flags[DH_HALT_BIT]) begin
          prescale_next = prescale_inc;
          if (prescale_inc == TICKS_PER_SECOND) begin
            prescale_next = '0;
            // seconds -> minutes -> hours -> days ripple
            if (sec_inc != SEC_WRAP) begin
              sec_next = sec_inc[SEC_W-1:0];
            end else begin
              sec_next = '0;
              if (min_inc != MIN_WRAP) begin
                min_next = min_inc[MIN_W-1:0];
              end else begin
                min_next = '0;
                if (hour_inc != HOUR_WRAP) begin
                  hour_next = hour_inc[HOUR_W-1:0];
                end else begin
                  hour_next                 = '0;
                  day_low_next              = day_inc[BYTE_W-1:0];
                  day_high_next[DH_DAY_BIT] = day_inc[BYTE_W];
                  if (day_inc[DAY_W]) begin
                    day_high_next[DH_CARRY_BIT] = 1'b1;
                  end
                end
              end
            end
          end
        end
      end
      FUNC_READ: begin
        case (reg_addr)
          REG_SEC:      result = BYTE_W'(latched_time[SEC_W-1:0]) & MASK_SEC;
          REG_MIN:      result = BYTE_W'(latched_time[SEC_W +: MIN_W]) & MASK_MIN;
          REG_HOUR:     result = BYTE_W'(latched_time[SEC_W+MIN_W +: HOUR_W]) & MASK_HOUR;
          REG_DAY_LOW:  result = latched_time[SEC_W+MIN_W+HOUR_W +: BYTE_W];
          REG_DAY_HIGH: result = latched_time[LATCH_W-1 -: BYTE_W] & MASK_DAY_HIGH;
          default:      result = READ_UNKNOWN;
        endcase
      end
      FUNC_WRITE: begin
        case (reg_addr)
          REG_SEC: begin
            sec_next      = write_data[SEC_W-1:0];
            prescale_next = '0;
          end
          REG_MIN:      min_next      = write_data[MIN_W-1:0];
          REG_HOUR:     hour_next     = write_data[HOUR_W-1:0];
          REG_DAY_LOW:  day_low_next  = write_data;
          REG_DAY_HIGH: day_high_next = write_data & MASK_DAY_HIGH;
          default: ;
        endcase
      end
      FUNC_LATCH: begin
        latched_next = {day_high_flags, day_low_byte, hour_count, min_count, sec_count};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prescale_count <= '0;
      sec_count      <= '0;
      min_count      <= '0;
      hour_count     <= '0;
      day_low_byte   <= '0;
      day_high_flags <= '0;
      latched_time   <= '0;
    end else if (accept_in) begin
      prescale_count <= prescale_next;
      sec_count      <= sec_next;
      min_count      <= min_next;
      hour_count     <= hour_next;
      day_low_byte   <= day_low_next;
      day_high_flags <= day_high_next;
      latched_time   <= latched_next;
    end
  end

  // result register with skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (take_out && skid_valid) begin
      out_data   <= skid_data;
      skid_valid <= 1'b0;
    end else if (accept_in && (!out_valid || take_out)) begin
      out_data  <= result;
      out_valid <= 1'b1;
    end else if (accept_in) begin
      skid_data  <= result;
      skid_valid <= 1'b1;
    end else if (take_out) begin
      out_valid <= 1'b0;
    end
  end

endmodule : cartridge_rtc_registers_core
`default_nettype wire

@@ tb/cartridge_rtc_registers_core_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cartridge_rtc_registers_core_checker
// watches both stream ports of the clock block, predicts each result byte
// ----------------------------------------------------------------------------
// Every accepted request runs through a cycle-free model of the clock
// (prescaler, time fields, halt, latch copy) and leaves one expected byte.
// Every accepted result is compared with the oldest expected byte.
// Mismatches and results with nothing expected are counted and reported.
module cartridge_rtc_registers_core_checker (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_axis_tvalid,
  input  wire logic                             s_axis_tready,
  // reg_addr[7:0], write_data[15:8]
  input  wire logic [crtc_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // func[1:0]
  input  wire logic [crtc_pkg::FUNC_W-1:0]      s_axis_tuser,
  input  wire logic                             m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // read_data[7:0]
  input  wire logic [crtc_pkg::BYTE_W-1:0]      m_axis_tdata,
  output int                                    outstanding,
  output int                                    mismatches
);
  import crtc_pkg::*;

  logic [PRESCALE_W-1:0] prescale;
  logic [SEC_W-1:0]      sec_now;
  logic [MIN_W-1:0]      min_now;
  logic [HOUR_W-1:0]     hour_now;
  logic [BYTE_W-1:0]     day_low_now;
  logic [BYTE_W-1:0]     day_high_now;
  logic                  halted;
  logic [LATCH_W-1:0]    time_copy;

  logic [BYTE_W-1:0]     expected_bytes[$];
  int                    fail_total = 0;

  function automatic void clear_clock();
    prescale     = '0;
    sec_now      = '0;
    min_now      = '0;
    hour_now     = '0;
    day_low_now  = '0;
    day_high_now = '0;
    halted       = 1'b0;
    time_copy    = '0;
  endfunction

  // seconds and minutes carry only on reaching 60, hours only on 24
  function automatic void advance_one_second();
    logic [SEC_W:0]  s_next;
    logic [MIN_W:0]  m_next;
    logic [HOUR_W:0] h_next;
    logic [DAY_W:0]  d_next;
    s_next = {1'b0, sec_now} + 1'b1;
    if (s_next != SEC_WRAP) begin
      sec_now = s_next[SEC_W-1:0];
    end else begin
      sec_now = '0;
      m_next = {1'b0, min_now} + 1'b1;
      if (m_next != MIN_WRAP) begin
        min_now = m_next[MIN_W-1:0];
      end else begin
        min_now = '0;
        h_next = {1'b0, hour_now} + 1'b1;
        if (h_next != HOUR_WRAP) begin
          hour_now = h_next[HOUR_W-1:0];
        end else begin
          hour_now = '0;
          d_next = {1'b0, day_high_now[DH_DAY_BIT], day_low_now} + 1'b1;
          if (d_next[DAY_W]) begin
            day_high_now[DH_CARRY_BIT] = 1'b1;
          end
          day_low_now = d_next[BYTE_W-1:0];
          day_high_now[DH_DAY_BIT] = d_next[BYTE_W];
        end
      end
    end
  endfunction

  function automatic logic [BYTE_W-1:0] apply_request(func_t op, logic [ADDR_W-1:0] addr,
                                                      logic [BYTE_W-1:0] wdata);
    logic [BYTE_W-1:0] result;
    result = '0;
    case (op)
      FUNC_TICK: begin
        if (!halted) begin
          prescale = prescale + 1'b1;
          if (prescale == TICKS_PER_SECOND) begin
            prescale = '0;
            advance_one_second();
          end
        end
      end
      FUNC_READ: begin
        case (addr)
          REG_SEC:      result = {2'b00, time_copy[5:0]} & MASK_SEC;
          REG_MIN:      result = {2'b00, time_copy[11:6]} & MASK_MIN;
          REG_HOUR:     result = {3'b000, time_copy[16:12]} & MASK_HOUR;
          REG_DAY_LOW:  result = time_copy[24:17];
          REG_DAY_HIGH: result = time_copy[32:25] & MASK_DAY_HIGH;
          default:      result = READ_UNKNOWN;
        endcase
      end
      FUNC_WRITE: begin
        case (addr)
          REG_SEC: begin
            sec_now  = wdata[SEC_W-1:0];
            prescale = '0;
          end
          REG_MIN:     min_now     = wdata[MIN_W-1:0];
          REG_HOUR:    hour_now    = wdata[HOUR_W-1:0];
          REG_DAY_LOW: day_low_now = wdata;
          REG_DAY_HIGH: begin
            day_high_now = wdata & MASK_DAY_HIGH;
            halted       = wdata[DH_HALT_BIT];
          end
          default: ;
        endcase
      end
      default: begin
        time_copy = {day_high_now, day_low_now, hour_now, min_now, sec_now};
      end
    endcase
    return result;
  endfunction

  always @(posedge clk) begin : watch
    logic [BYTE_W-1:0] want;
    if (rst) begin
      clear_clock();
      expected_bytes.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_bytes.push_back(apply_request(func_t'(s_axis_tuser),
                                               s_axis_tdata[ADDR_W-1:0],
                                               s_axis_tdata[IN_DATA_W-1:ADDR_W]));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_bytes.size() == 0) begin
          $error("read_data: expected none, actual %02h", m_axis_tdata);
          fail_total++;
        end else begin
          want = expected_bytes.pop_front();
          if (m_axis_tdata !== want) begin
            $error("read_data: expected %02h, actual %02h", want, m_axis_tdata);
            fail_total++;
          end
        end
      end
    end
    outstanding <= expected_bytes.size();
    mismatches  <= fail_total;
  end

endmodule : cartridge_rtc_registers_core_checker
`default_nettype wire

@@ tb/cartridge_rtc_registers_core_test.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cartridge_rtc_registers_core_test
// stimulus and verdict for the cartridge real-time clock register block
// ----------------------------------------------------------------------------
// Directed requests walk every register at its extremes, unknown addresses,
// the halt bit and the latch. Random requests follow, mostly
// write-latch-read sequences, with random gaps on the request side and
// random stalls on the result side; midway the sender stops until every
// result has come back.
module cartridge_rtc_registers_core_test;
  import crtc_pkg::*;

  localparam int CYCLE_LIMIT  = 20_000_000;
  localparam int RANDOM_ITEMS = 1900;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata = '0;
  logic [FUNC_W-1:0]    s_axis_tuser = FUNC_TICK;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [BYTE_W-1:0]    m_axis_tdata;

  int   outstanding;
  int   mismatches;
  logic steady = 1'b0;
  int   stall_left = 0;
  int   stall_roll;
  int   cycle_count = 0;
  int   op_counts[4] = '{0, 0, 0, 0};

  always #5 clk = ~clk;

  cartridge_rtc_registers_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  cartridge_rtc_registers_core_checker checker_inst (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .outstanding   (outstanding),
    .mismatches    (mismatches)
  );

  // result side stalls: mostly short, a few long
  always @(posedge clk) begin
    if (rst || steady) begin
      m_axis_tready <= 1'b1;
      stall_left    <= 0;
    end else if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else begin
      stall_roll = $urandom_range(0, 99);
      if (stall_roll < 70) begin
        m_axis_tready <= 1'b1;
      end else if (stall_roll < 96) begin
        m_axis_tready <= 1'b0;
        stall_left    <= $urandom_range(0, 3);
      end else begin
        m_axis_tready <= 1'b0;
        stall_left    <= $urandom_range(15, 50);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, outstanding);
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (steady || roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // returns at the edge where the request is taken
  task automatic send(func_t op, logic [ADDR_W-1:0] addr, logic [BYTE_W-1:0] wdata);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {wdata, addr};
    s_axis_tuser  <= op;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    op_counts[op]++;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  function automatic logic [ADDR_W-1:0] pick_addr();
    if ($urandom_range(0, 9) == 0) return ADDR_W'($urandom);
    return REG_SEC + ADDR_W'($urandom_range(0, 4));
  endfunction

  initial begin
    func_t             op;
    logic [ADDR_W-1:0] addr;
    int                roll;
    int                sent;
    logic              paused;
    paused = 1'b0;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: registers at reset, all-ones writes, unknown addresses, halt
    for (int a = REG_SEC; a <= REG_DAY_HIGH; a++) send(FUNC_READ, ADDR_W'(a), 8'h00);
    send(FUNC_READ, 8'h00, 8'hFF);
    send(FUNC_READ, 8'hFF, 8'h00);
    for (int a = REG_SEC; a <= REG_DAY_HIGH; a++) send(FUNC_WRITE, ADDR_W'(a), 8'hFF);
    send(FUNC_WRITE, 8'h07, 8'hFF);
    send(FUNC_TICK, 8'hFF, 8'hFF);
    send(FUNC_LATCH, 8'h00, 8'h00);
    for (int a = REG_SEC; a <= REG_DAY_HIGH; a++) send(FUNC_READ, ADDR_W'(a), 8'h00);
    send(FUNC_READ, 8'h0D, 8'h00);
    send(FUNC_WRITE, REG_DAY_HIGH, 8'h00);
    send(FUNC_TICK, 8'h00, 8'h00);

    // random: mostly write-latch-read sequences, the rest loose requests
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent % 400 >= 300) steady <= 1'b1;
      else steady <= 1'b0;
      if (!paused && sent >= RANDOM_ITEMS / 2) begin
        wait_drained();
        paused = 1'b1;
      end
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
        addr = pick_addr();
        send(FUNC_WRITE, addr, BYTE_W'($urandom));
        repeat ($urandom_range(0, 3)) begin
          send(FUNC_TICK, ADDR_W'($urandom), BYTE_W'($urandom));
          sent++;
        end
        send(FUNC_LATCH, ADDR_W'($urandom), BYTE_W'($urandom));
        send(FUNC_READ, addr, BYTE_W'($urandom));
        sent += 3;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 40) op = FUNC_TICK;
        else if (roll < 65) op = FUNC_READ;
        else if (roll < 85) op = FUNC_WRITE;
        else op = FUNC_LATCH;
        send(op, pick_addr(), BYTE_W'($urandom));
        sent++;
      end
    end
    s_axis_tvalid <= 1'b0;
    steady <= 1'b0;

    wait_drained();
    repeat (16) @(posedge clk);
    $display("requests: %0d ticks, %0d reads, %0d writes, %0d latches",
             op_counts[FUNC_TICK], op_counts[FUNC_READ], op_counts[FUNC_WRITE],
             op_counts[FUNC_LATCH]);
    $display("covered register extremes, halt, unknown addresses and a full drain midway");
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule : cartridge_rtc_registers_core_test
`default_nettype wire
